// File: hw/rtl/hed_pkg.sv
// ----------------------------------------------------------------------------
// hed_pkg
// Shared constants, name tables and controller/datapath types for the
// html entity decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

    typedef logic [7:0] byte_t;

    // capture window and derived widths
    localparam int LOOKAHEAD  = 10;
    localparam int CNT_W      = $clog2(LOOKAHEAD + 1);
    localparam int HIDX_W     = $clog2(LOOKAHEAD);
    localparam int BUF_AW     = $clog2(LOOKAHEAD + 2);
    localparam int BUF_DEPTH  = 2 ** BUF_AW;
    localparam int NAME_CHARS = 6;
    localparam int NAME_W     = 8 * NAME_CHARS;
    localparam int N_ASCII    = 7;
    localparam int N_LATIN    = 96;

    // character and encoding constants
    localparam byte_t CH_AMP     = 8'h26;
    localparam byte_t CH_SEMI    = 8'h3B;
    localparam int    LATIN_BASE = 160;
    localparam byte_t UTF8_LEAD  = 8'hC0;
    localparam byte_t UTF8_CONT  = 8'h80;
    localparam byte_t UTF8_MASK  = 8'h3F;

    // names are right-aligned, zero padded on the left
    localparam logic [NAME_W-1:0] ASCII_NAMES [N_ASCII] = '{
        "amp", "lt", "gt", "quot", "apos", "#39", "#039"
    };
    localparam byte_t ASCII_CODES [N_ASCII] = '{
        8'h26, 8'h3C, 8'h3E, 8'h22, 8'h27, 8'h27, 8'h27
    };
    localparam logic [NAME_W-1:0] LATIN_NAMES [N_LATIN] = '{
        "nbsp", "iexcl", "cent", "pound", "curren", "yen", "brvbar", "sect",
        "uml", "copy", "ordf", "laquo", "not", "shy", "reg", "macr",
        "deg", "plusmn", "sup2", "sup3", "acute", "micro", "para", "middot",
        "cedil", "sup1", "ordm", "raquo", "frac14", "frac12", "frac34", "iquest",
        "Agrave", "Aacute", "Acirc", "Atilde", "Auml", "Aring", "AElig", "Ccedil",
        "Egrave", "Eacute", "Ecirc", "Euml", "Igrave", "Iacute", "Icirc", "Iuml",
        "ETH", "Ntilde", "Ograve", "Oacute", "Ocirc", "Otilde", "Ouml", "times",
        "Oslash", "Ugrave", "Uacute", "Ucirc", "Uuml", "Yacute", "THORN", "szlig",
        "agrave", "aacute", "acirc", "atilde", "auml", "aring", "aelig", "ccedil",
        "egrave", "eacute", "ecirc", "euml", "igrave", "iacute", "icirc", "iuml",
        "eth", "ntilde", "ograve", "oacute", "ocirc", "otilde", "ouml", "divide",
        "oslash", "ugrave", "uacute", "ucirc", "uuml", "yacute", "thorn", "yuml"
    };

    // lookup result
    typedef struct packed {
        logic  hit;
        logic  two;
        byte_t b0;
        byte_t b1;
    } lookup_t;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic proc;
        logic hit_emit;
        logic emit2;
        logic fail;
        logic flush;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_valid;
        logic q_empty;
        logic q_one;
        logic capturing;
        logic head_amp;
        logic head_semi;
        logic at_limit;
        logic hit;
        logic two;
        logic last;
        logic can_emit;
    } status_t;

endpackage

// File: hw/rtl/hed_if.sv
// ----------------------------------------------------------------------------
// hed_in_if / hed_out_if
// Valid/ready stream channels for escaped input text and decoded output.
// ----------------------------------------------------------------------------
interface hed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface hed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// File: hw/rtl/hed_ctrl.sv
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer for the entity decoder: input transfer, byte scan, name lookup,
// second utf-8 byte, capture failure and end-of-string flush.
// ----------------------------------------------------------------------------
module hed_ctrl
    import hed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_RUN   = 6'b000010,
        S_LOOK  = 6'b000100,
        S_EMIT2 = 6'b001000,
        S_FAIL  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // where to go once the pending bytes are used up
    function automatic state_t step_end(input logic last, input logic cap);
        state_t s;
        if (last && cap) begin
            s = S_FAIL;
        end else if (last) begin
            s = S_FLUSH;
        end else begin
            s = S_IDLE;
        end
        return s;
    endfunction

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (status.q_empty) begin
                    state_next = step_end(status.last, status.capturing);
                end else if (status.can_emit) begin
                    cmd.proc = 1'b1;
                    if (status.capturing && status.head_semi) begin
                        state_next = S_LOOK;
                    end else if (status.capturing && status.at_limit) begin
                        state_next = S_FAIL;
                    end else if (status.q_one) begin
                        state_next = step_end(status.last,
                                              status.capturing || status.head_amp);
                    end
                end
            end
            S_LOOK:
            begin
                if (!status.hit) begin
                    state_next = S_FAIL;
                end else if (status.can_emit) begin
                    cmd.hit_emit = 1'b1;
                    if (status.two) begin
                        state_next = S_EMIT2;
                    end else if (status.q_empty) begin
                        state_next = step_end(status.last, 1'b0);
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            S_EMIT2:
            begin
                if (status.can_emit) begin
                    cmd.emit2 = 1'b1;
                    if (status.q_empty) begin
                        state_next = step_end(status.last, 1'b0);
                    end else begin
                        state_next = S_RUN;
                    end
                end
            end
            S_FAIL:
            begin
                if (status.can_emit) begin
                    cmd.fail   = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_FLUSH:
            begin
                if (status.can_emit) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/hed_datapath.sv
// ----------------------------------------------------------------------------
// hed_datapath
// Replay buffer, capture window, name table compare, one-byte hold-back and
// output register of the entity decoder.
// ----------------------------------------------------------------------------
module hed_datapath
    import hed_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    hed_in_if.sink           in_ch,
    hed_out_if.source        out_ch,
    input  cmd_t             cmd,
    output status_t          status
);

    // replay buffer: bytes from the capture start onward stay until resolved
    byte_t             buf_reg [BUF_DEPTH];
    logic [BUF_AW-1:0] wr_reg, rd_reg, cs_reg;

    // capture window
    byte_t             held_reg [LOOKAHEAD];
    logic [CNT_W-1:0]  cnt_reg;
    logic              cap_reg;
    logic              last_reg;
    lookup_t           lk_reg;

    // hold-back byte and output register
    byte_t             pend_reg;
    logic              pend_valid_reg;
    byte_t             out_byte_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    byte_t             head;
    lookup_t           lk_now;
    logic              can_emit;
    logic              emit;
    byte_t             emit_byte;
    logic [CNT_W-1:0]  name_len;

    // compare one table name with the held bytes
    function automatic logic name_eq(input logic [NAME_W-1:0] nm,
                                     input byte_t h [LOOKAHEAD],
                                     input logic [CNT_W-1:0] len);
        logic eq;
        logic ok;
        eq = 1'b0;
        for (int k = 1; k <= NAME_CHARS; k++) begin
            ok = (len == CNT_W'(k)) && (nm[8*k-1 -: 8] != 8'd0) && ((nm >> (8*k)) == '0);
            for (int i = 0; i < k; i++) begin
                ok = ok && (h[i] == nm[8*(k-1-i) +: 8]);
            end
            if (ok) begin
                eq = 1'b1;
            end
        end
        return eq;
    endfunction

    // ascii names first, then latin-1 names
    function automatic lookup_t name_lookup(input byte_t h [LOOKAHEAD],
                                            input logic [CNT_W-1:0] len);
        lookup_t r;
        byte_t   code;
        r = '0;
        for (int i = 0; i < N_ASCII; i++) begin
            if (!r.hit && name_eq(ASCII_NAMES[i], h, len)) begin
                r.hit = 1'b1;
                r.b0  = ASCII_CODES[i];
            end
        end
        for (int i = 0; i < N_LATIN; i++) begin
            if (!r.hit && name_eq(LATIN_NAMES[i], h, len)) begin
                code  = 8'(LATIN_BASE + i);
                r.hit = 1'b1;
                r.two = 1'b1;
                r.b0  = UTF8_LEAD | (code >> 6);
                r.b1  = UTF8_CONT | (code & UTF8_MASK);
            end
        end
        return r;
    endfunction

    // head byte, lookup and emit selection
    assign head     = buf_reg[rd_reg];
    assign name_len = cnt_reg - CNT_W'(1);
    assign lk_now   = name_lookup(held_reg, name_len);
    assign can_emit = !pend_valid_reg || !out_valid_reg || out_ch.ready;

    always_comb
    begin
        emit      = 1'b0;
        emit_byte = head;
        if (cmd.proc && !cap_reg && (head != CH_AMP)) begin
            emit = 1'b1;
        end else if (cmd.hit_emit) begin
            emit      = 1'b1;
            emit_byte = lk_now.b0;
        end else if (cmd.emit2) begin
            emit      = 1'b1;
            emit_byte = lk_reg.b1;
        end else if (cmd.fail) begin
            emit      = 1'b1;
            emit_byte = CH_AMP;
        end
    end

    // status to controller
    always_comb
    begin
        status.in_valid  = in_ch.valid;
        status.q_empty   = (rd_reg == wr_reg);
        status.q_one     = (rd_reg + BUF_AW'(1) == wr_reg);
        status.capturing = cap_reg;
        status.head_amp  = (head == CH_AMP);
        status.head_semi = (head == CH_SEMI);
        status.at_limit  = (cnt_reg == CNT_W'(LOOKAHEAD - 1));
        status.hit       = lk_now.hit;
        status.two       = lk_now.two;
        status.last      = last_reg;
        status.can_emit  = can_emit;
    end

    // buffer and held byte storage
    always_ff @(posedge clk)
    begin
        if (cmd.accept) begin
            buf_reg[wr_reg] <= in_ch.in_byte;
        end
        if (cmd.proc && cap_reg) begin
            held_reg[cnt_reg[HIDX_W-1:0]] <= head;
        end
        if (cmd.hit_emit) begin
            lk_reg <= lk_now;
        end
        if (emit) begin
            pend_reg <= emit_byte;
        end
        if ((emit && pend_valid_reg) || cmd.flush) begin
            out_byte_reg <= pend_reg;
        end
    end

    // pointers and capture control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            cs_reg   <= '0;
            cnt_reg  <= '0;
            cap_reg  <= 1'b0;
            last_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                wr_reg   <= wr_reg + BUF_AW'(1);
                last_reg <= in_ch.last_byte;
            end
            if (cmd.proc) begin
                rd_reg <= rd_reg + BUF_AW'(1);
                if (cap_reg) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end else if (head == CH_AMP) begin
                    cap_reg <= 1'b1;
                    cnt_reg <= '0;
                    cs_reg  <= rd_reg + BUF_AW'(1);
                end
            end
            if (cmd.hit_emit) begin
                cap_reg <= 1'b0;
                cnt_reg <= '0;
            end
            if (cmd.fail) begin
                rd_reg  <= cs_reg;
                cap_reg <= 1'b0;
                cnt_reg <= '0;
            end
        end
    end

    // hold-back and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end else begin
            if (emit) begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= 1'b0;
                end else if (out_ch.ready) begin
                    out_valid_reg <= 1'b0;
                end
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
                out_last_reg   <= 1'b1;
            end else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // channel outputs
    assign in_ch.ready     = cmd.in_ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.out_byte = out_byte_reg;
    assign out_ch.out_last = out_last_reg;

    // flush always has a held-back byte to mark as last
    a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |-> pend_valid_reg)
        else $error("flush without held-back byte");

    // pending bytes never exceed what one step can replay
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (BUF_AW'(wr_reg - rd_reg) <= BUF_AW'(LOOKAHEAD + 1)))
        else $error("replay buffer overfilled");

    // window count is cleared whenever no capture is open
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !cap_reg |-> (cnt_reg == '0))
        else $error("held count nonzero outside capture");

endmodule

// File: hw/rtl/html_entity_decoder_core.sv
// ----------------------------------------------------------------------------
// html_entity_decoder_core
// Streaming html entity decoder, latin-1 names to utf-8.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries escaped text one byte per transfer, last_byte marking the
//   end of a string; out_ch carries decoded bytes, out_last on the final one.
//   A plain byte takes an input transfer, then a scan, before in_ch is
//   ready again; the final byte of a string adds a flush step to release
//   the held-back byte with out_last. A byte that closes a name adds a
//   name table compare step and, for a latin-1 name, a step for the second
//   utf-8 byte. A failed capture emits the '&' and then scans each held byte
//   again from the replay buffer; the input is not taken during that time.
//   One decoded byte is held back until the next one is produced or the
//   string ends, so it can carry out_last; output appears one byte later
//   than the scan that made it. The output register frees the scan from the
//   receiver: while out_ch is stalled the scan runs until it has a second
//   byte ready, then waits.
//   After reset no capture is open, both channels are empty, and in_ch is
//   ready at once.
// ----------------------------------------------------------------------------
module html_entity_decoder_core
    import hed_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    hed_in_if.sink    in_ch,
    hed_out_if.source out_ch
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    hed_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    // buffers, lookup and output
    hed_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .status (status)
    );

endmodule

// File: sim/hed_decode_scoreboard.sv
// ----------------------------------------------------------------------------
// hed_decode_scoreboard
// Predicts decoded bytes from accepted input bytes and checks output transfers.
// ----------------------------------------------------------------------------
class hed_decode_scoreboard;

    // decoder state copy
    bit             in_capture;
    hed_pkg::byte_t name_buf [hed_pkg::LOOKAHEAD];
    int             name_len;

    // pending decoded bytes, {last, byte}
    bit [8:0]       decoded_q [$];
    int             errors;

    function new();
        in_capture = 0;
        name_len   = 0;
        errors     = 0;
    endfunction

    // compare a right-aligned table name with the held name
    function bit name_match(logic [hed_pkg::NAME_W-1:0] nm, int len);
        int k;
        int nlen;
        nlen = 0;
        for (k = 0; k < hed_pkg::NAME_CHARS; k++)
            if (nm[8*k +: 8] != 8'h00) nlen = k + 1;
        if (nlen != len) return 0;
        for (k = 0; k < len; k++)
            if (nm[8*(len-1-k) +: 8] != name_buf[k]) return 0;
        return 1;
    endfunction

    // predict results of one accepted input byte
    function void note_input(hed_pkg::byte_t b_in, bit last);
        hed_pkg::byte_t scan_q [$];
        hed_pkg::byte_t out_q  [$];
        hed_pkg::byte_t b;
        hed_pkg::byte_t fresh  [$];
        bit             fail;
        bit             hit;
        int             i;
        int             code;
        scan_q.push_back(b_in);
        forever
        begin
            fail = 0;
            if (scan_q.size() == 0)
            begin
                if (!(last && in_capture)) break;
                fail = 1;
            end
            else
            begin
                b = scan_q.pop_front();
                if (!in_capture)
                begin
                    if (b == hed_pkg::CH_AMP)
                    begin
                        in_capture = 1;
                        name_len   = 0;
                    end
                    else
                        out_q.push_back(b);
                    continue;
                end
                if (name_len < hed_pkg::LOOKAHEAD)
                begin
                    name_buf[name_len] = b;
                    name_len++;
                end
                if (b == hed_pkg::CH_SEMI)
                begin
                    hit = 0;
                    for (i = 0; i < hed_pkg::N_ASCII && !hit; i++)
                        if (name_match(hed_pkg::ASCII_NAMES[i], name_len - 1))
                        begin
                            out_q.push_back(hed_pkg::ASCII_CODES[i]);
                            hit = 1;
                        end
                    for (i = 0; i < hed_pkg::N_LATIN && !hit; i++)
                        if (name_match(hed_pkg::LATIN_NAMES[i], name_len - 1))
                        begin
                            code = hed_pkg::LATIN_BASE + i;
                            out_q.push_back(8'hC0 | 8'(code >> 6));
                            out_q.push_back(8'h80 | 8'(code & 8'h3F));
                            hit = 1;
                        end
                    if (hit)
                    begin
                        in_capture = 0;
                        name_len   = 0;
                    end
                    else
                        fail = 1;
                end
                else if (name_len >= hed_pkg::LOOKAHEAD)
                    fail = 1;
            end
            // failed capture: send the ampersand and rescan held bytes
            if (fail)
            begin
                out_q.push_back(hed_pkg::CH_AMP);
                fresh.delete();
                for (i = 0; i < name_len; i++) fresh.push_back(name_buf[i]);
                foreach (scan_q[j]) fresh.push_back(scan_q[j]);
                scan_q     = fresh;
                in_capture = 0;
                name_len   = 0;
            end
        end
        foreach (out_q[j])
            decoded_q.push_back({last && (j == out_q.size() - 1), out_q[j]});
    endfunction

    // check one output transfer against the oldest prediction
    function void check_output(hed_pkg::byte_t b, bit last);
        bit [8:0] exp_v;
        if (decoded_q.size() == 0)
        begin
            $display("%0t: unexpected output byte %h last %0d", $time, b, last);
            errors++;
            return;
        end
        exp_v = decoded_q.pop_front();
        if (exp_v[7:0] !== b)
        begin
            $display("%0t: out_byte expected %h actual %h", $time, exp_v[7:0], b);
            errors++;
        end
        if (exp_v[8] !== last)
        begin
            $display("%0t: out_last expected %0d actual %0d", $time, exp_v[8], last);
            errors++;
        end
    endfunction

endclass

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives escaped strings into the entity decoder: directed entities, failing
// captures and random well-formed and noisy text, with random idle cycles on
// both channels; every decoded byte is checked against a predictor.
// ----------------------------------------------------------------------------
module testbench
    import hed_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   sent;

    hed_in_if  in_ch();
    hed_out_if out_ch();

    hed_decode_scoreboard decode_sb;

    html_entity_decoder_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // time limit
    initial
    begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

    // idle roll, none during quiet stretch
    function bit idle_roll();
        return !quiet && ($urandom_range(99) < 12);
    endfunction

    // send one byte with random leading gaps
    task automatic send_byte(byte_t b, bit last);
        while (idle_roll())
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.in_byte   <= b;
        in_ch.last_byte <= last;
        do @(posedge clk); while (!in_ch.ready);
        decode_sb.note_input(b, last);
        sent++;
    endtask

    task automatic send_str(string s, bit last_end);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i], last_end && (i == s.len() - 1));
    endtask

    // random string: entities, some broken or noise
    task automatic send_random_string();
        string s;
        int    n;
        int    k;
        int    r;
        logic [NAME_W-1:0] nm;
        s = "";
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++)
        begin
            r = $urandom_range(9);
            if (r < 4)
            begin
                nm = (r < 2) ? LATIN_NAMES[$urandom_range(N_LATIN - 1)]
                             : ASCII_NAMES[$urandom_range(N_ASCII - 1)];
                s = {s, "&"};
                for (int c = NAME_CHARS - 1; c >= 0; c--)
                    if (nm[8*c +: 8] != 0) s = {s, string'(nm[8*c +: 8])};
                if ($urandom_range(9) != 0) s = {s, ";"};
            end
            else if (r < 6)
                s = {s, "&", string'(byte_t'($urandom_range(32, 126))), ";"};
            else if (r < 8)
                s = {s, string'(byte_t'($urandom_range(255)))};
            else
            begin
                s = {s, "&"};
                repeat ($urandom_range(0, 12))
                    s = {s, string'(($urandom_range(3) == 0) ? "&" : "x")};
            end
        end
        for (k = 0; k < s.len(); k++)
            send_byte(s[k] == 0 ? 8'h00 : s[k], 0);
        send_byte(byte_t'($urandom_range(255)), 1);
    endtask

    // output side: random ready, check each transfer
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                decode_sb.check_output(out_ch.out_byte, out_ch.out_last);
            out_ch.ready <= !idle_roll();
        end
    end

    // stimulus
    initial
    begin
        int wait_cnt;
        decode_sb       = new();
        quiet           = 0;
        sent            = 0;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = 8'h00;
        in_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed strings
        send_str("&amp;&lt;&gt;", 0);
        send_str("&quot;&apos;&#39;&#039;", 1);
        send_str("&nbsp;&yuml;&AElig;&;", 1);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 1);
        send_str("&abcdefghij;&a&lt;&amp", 1);
        send_byte(CH_AMP, 1);
        in_ch.valid <= 1'b0;

        // sender holds off until everything has drained
        while (decode_sb.decoded_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        // random, with a quiet stretch
        while (sent < 400)
        begin
            quiet = (sent > 200 && sent < 280);
            send_random_string();
        end
        quiet = 0;
        in_ch.valid <= 1'b0;

        wait_cnt = 0;
        while (decode_sb.decoded_q.size() != 0 && wait_cnt < 100000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (50) @(posedge clk);
        if (decode_sb.errors == 0 && decode_sb.decoded_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
